[hw/rtl/humidity_temp_frame_decoder_top_assert.svh]
// Assertion macros for the frame decoder RTL.
// The including module must have clk_i and rst_ni in scope.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define HTFD_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("htfd: same-cycle check failed");

// Next-cycle implication.
`define HTFD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("htfd: next-cycle check failed");

`endif

[hw/rtl/htfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package htfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 3;
  localparam int unsigned PayloadW = 40;
  localparam int unsigned RawW     = 20;
  localparam int unsigned ShiftW   = 20;
  localparam int unsigned HumW     = 17;
  localparam int unsigned TempW    = 19;
  localparam int unsigned HumCoefW  = 17;
  localparam int unsigned TempCoefW = 18;

  localparam logic [ByteW-1:0]  CrcInit   = 8'hFF;
  localparam logic [ByteW-1:0]  CrcPoly   = 8'h31;
  localparam logic [CountW-1:0] LastIdx   = 3'd6;
  localparam logic [CountW-1:0] FirstIdx  = 3'd0;

  localparam logic [HumCoefW-1:0]  HumCoeff   = 17'(1000 * 100);
  localparam logic [TempCoefW-1:0] TempCoeff  = 18'(1000 * 200);
  localparam logic signed [TempW-1:0] TempOffset = 19'sd50000;

  // A completed frame handed from the byte collector to the scaling stage.
  typedef struct packed {
    logic [PayloadW-1:0] payload;
    logic                crc_error;
  } htfd_frame_t;

  // One byte through the CRC-8, MSB first, no reflection.
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < ByteW; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/htfd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Received frame bytes.
interface htfd_in_if;
  import htfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  logic             frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Decoded measurements.
interface htfd_out_if;
  import htfd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [HumW-1:0]         humidity_milli_pct;
  logic signed [TempW-1:0] temperature_milli_c;
  logic                    crc_error;

  modport source (output valid, output humidity_milli_pct, output temperature_milli_c,
                  output crc_error, input ready);
  modport sink   (input valid, input humidity_milli_pct, input temperature_milli_c,
                  input crc_error, output ready);
endinterface

`default_nettype wire

[hw/rtl/humidity_temp_frame_decoder_top.sv]
// Channel  Dir  Payload                                          Moves
// in_i     in   rx_byte[7:0], frame_start                        one request per frame byte
// out_o    out  humidity_milli_pct[16:0], temperature_milli_c    one request per frame
//               [18:0] signed, crc_error
//
// A byte can be accepted in every cycle while in_i.ready is high; the seventh
// byte of a frame yields a result through the frame register, then the result register.
// Reset clears the byte counter, the CRC to 0xFF and both valid flags.
// A stalled result holds in the output register while the frame register still
// takes one more finished frame; only when both are full does in_i.ready drop.
`timescale 1ns / 1ps
`default_nettype none

module humidity_temp_frame_decoder_top
  import htfd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  htfd_in_if.sink     in_i,
  htfd_out_if.source  out_o
);

  // Frame handoff between the byte collector and the scaling stage.
  htfd_frame_t rec;
  logic        rec_valid;
  logic        rec_ready;

  // The collector runs the CRC-8 one byte per request and assembles the five
  // payload bytes; on the CRC byte it registers the payload with the check
  // result and restarts the counter for the next frame.
  htfd_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .rx_byte_i     (in_i.rx_byte),
    .frame_start_i (in_i.frame_start),
    .rec_valid_o   (rec_valid),
    .rec_ready_i   (rec_ready),
    .rec_o         (rec)
  );

  // The scaling stage applies one multiplier per field, then the temperature
  // offset, and registers the result for the output channel.
  htfd_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (rec_valid),
    .rec_ready_o   (rec_ready),
    .rec_i         (rec),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .humidity_o    (out_o.humidity_milli_pct),
    .temperature_o (out_o.temperature_milli_c),
    .crc_error_o   (out_o.crc_error)
  );

endmodule

`default_nettype wire

[hw/rtl/htfd_frame.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "humidity_temp_frame_decoder_top_assert.svh"

module htfd_frame
  import htfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire logic             frame_start_i,
  output logic                  rec_valid_o,
  input  wire logic             rec_ready_i,
  output htfd_frame_t           rec_o
);

  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [ByteW-1:0]    crc_q, crc_d;
  logic [PayloadW-1:0] payload_q, payload_d;
  logic                rec_v_q, rec_v_d;
  htfd_frame_t         rec_q, rec_d;

  logic                accept;
  logic [CountW-1:0]   idx;
  logic [ByteW-1:0]    crc_base;
  logic [ByteW-1:0]    crc_next;
  logic                is_last;

  assign in_ready_o = !rec_v_q || rec_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // A frame start forces this byte to be byte 0 with a fresh CRC.
  assign idx      = frame_start_i ? FirstIdx : cnt_q;
  assign crc_base = frame_start_i ? CrcInit : crc_q;
  assign crc_next = crc8_update(crc_base, rx_byte_i);
  assign is_last  = (idx == LastIdx);

  always_comb begin
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    payload_d = payload_q;
    rec_d     = rec_q;
    rec_v_d   = rec_v_q && !rec_ready_i;
    if (accept) begin
      if (is_last) begin
        cnt_d           = FirstIdx;
        crc_d           = CrcInit;
        rec_v_d         = 1'b1;
        rec_d.payload   = payload_q;
        rec_d.crc_error = (rx_byte_i != crc_base);
      end else begin
        cnt_d = idx + 3'd1;
        crc_d = crc_next;
        if (idx != FirstIdx) begin
          payload_d = {payload_q[PayloadW-ByteW-1:0], rx_byte_i};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= FirstIdx;
      crc_q   <= CrcInit;
      rec_v_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      rec_v_q <= rec_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    rec_q     <= rec_d;
  end

  assign rec_valid_o = rec_v_q;
  assign rec_o       = rec_q;

  `HTFD_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= LastIdx)
  `HTFD_ASSERT_NEXT(a_start_restarts, accept && frame_start_i,
                    cnt_q == 3'd1 && crc_q == $past(crc_next))
  `HTFD_ASSERT_NEXT(a_last_emits, accept && is_last,
                    rec_v_q && cnt_q == FirstIdx && crc_q == CrcInit)
  `HTFD_ASSERT_NEXT(a_rec_holds, rec_v_q && !rec_ready_i, rec_v_q && $stable(rec_q))

endmodule

`default_nettype wire

[hw/rtl/htfd_scale.sv]
`timescale 1ns / 1ps
`default_nettype none

module htfd_scale
  import htfd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rec_valid_i,
  output logic                     rec_ready_o,
  input  wire htfd_frame_t         rec_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [HumW-1:0]          humidity_o,
  output logic signed [TempW-1:0]  temperature_o,
  output logic                     crc_error_o
);

  localparam int unsigned HumProdW  = RawW + HumCoefW;
  localparam int unsigned TempProdW = RawW + TempCoefW;

  logic                    out_v_q;
  logic [HumW-1:0]         hum_q, hum_d;
  logic signed [TempW-1:0] temp_q, temp_d;
  logic                    err_q;
  logic                    load;

  logic [RawW-1:0]       raw_hum, temp_raw;
  logic [HumProdW-1:0]   hum_prod;
  logic [TempProdW-1:0]  temp_prod;
  logic [TempCoefW-1:0]  temp_scaled;

  assign rec_ready_o = !out_v_q || out_ready_i;
  assign load        = rec_valid_i && rec_ready_o;

  // Byte 1 is the most significant; humidity takes the top 20 bits.
  assign raw_hum  = rec_i.payload[PayloadW-1 -: RawW];
  assign temp_raw = rec_i.payload[RawW-1:0];

  assign hum_prod    = HumProdW'(raw_hum) * HumProdW'(HumCoeff);
  assign temp_prod   = TempProdW'(temp_raw) * TempProdW'(TempCoeff);
  assign hum_d       = hum_prod[ShiftW +: HumW];
  assign temp_scaled = temp_prod[ShiftW +: TempCoefW];
  assign temp_d      = signed'({1'b0, temp_scaled}) - TempOffset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rec_ready_o) begin
      out_v_q <= rec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hum_q  <= hum_d;
      temp_q <= temp_d;
      err_q  <= rec_i.crc_error;
    end
  end

  assign out_valid_o   = out_v_q;
  assign humidity_o    = hum_q;
  assign temperature_o = temp_q;
  assign crc_error_o   = err_q;

endmodule

`default_nettype wire

[tb/htfd_frame_checker.sv]
`timescale 1ns / 1ps

package htfd_frame_math_pkg;
  import htfd_pkg::*;

  localparam longint unsigned HumScale   = 100000;
  localparam longint unsigned TempScale  = 200000;
  localparam longint unsigned TempBias   = 50000;
  localparam int unsigned     FracBits   = 20;
  localparam int unsigned     FrameBytes = 7;

  // Serial form of the CRC-8: one data bit at a time, MSB first.
  function automatic logic [ByteW-1:0] crc8_poly31(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
    logic [ByteW-1:0] r;
    r = crc;
    for (int k = ByteW - 1; k >= 0; k--) begin
      if (r[ByteW-1] ^ data[k]) begin
        r = {r[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[ByteW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

module htfd_frame_checker
  import htfd_pkg::*;
  import htfd_frame_math_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  htfd_in_if        bytes_mon,
  htfd_out_if       readings_mon,
  output int        mismatch_count,
  output int        readings_pending
);

  typedef struct packed {
    logic [HumW-1:0]         humidity;
    logic signed [TempW-1:0] temperature;
    logic                    crc_error;
  } reading_t;

  reading_t expected_readings[$];

  logic [CountW-1:0]   frame_pos;
  logic [ByteW-1:0]    frame_crc;
  logic [PayloadW-1:0] payload_shift;

  // Advances the frame state by one byte; returns 1 with the decoded reading
  // when the byte closes a frame.
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic start,
                                     output reading_t rd);
    logic [RawW-1:0]   raw_hum;
    logic [RawW-1:0]   temp_raw;
    longint unsigned   hum_scaled;
    longint unsigned   temp_scaled;
    rd = '0;
    if (start) begin
      frame_pos = FirstIdx;
      frame_crc = CrcInit;
    end
    if (frame_pos < LastIdx) begin
      frame_crc = crc8_poly31(frame_crc, b);
      if (frame_pos != FirstIdx) begin
        payload_shift = {payload_shift[PayloadW-ByteW-1:0], b};
      end
      frame_pos = CountW'(frame_pos + 1);
      return 1'b0;
    end
    raw_hum        = payload_shift[PayloadW-1:RawW];
    temp_raw       = payload_shift[RawW-1:0];
    hum_scaled     = (64'(raw_hum) * HumScale) >> FracBits;
    temp_scaled    = (64'(temp_raw) * TempScale) >> FracBits;
    rd.humidity    = HumW'(hum_scaled);
    rd.temperature = TempW'(temp_scaled - TempBias);
    rd.crc_error   = (b != frame_crc);
    frame_pos      = FirstIdx;
    frame_crc      = CrcInit;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input reading_t exp_rd,
                                 input reading_t got_rd);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected hum=%0d temp=%0d crc_err=%0b, got hum=%0d temp=%0d crc_err=%0b",
               $realtime, what, exp_rd.humidity, $signed(exp_rd.temperature), exp_rd.crc_error,
               got_rd.humidity, $signed(got_rd.temperature), got_rd.crc_error);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got_rd;
    reading_t exp_rd;
    reading_t new_rd;
    if (!rst_ni) begin
      expected_readings.delete();
      frame_pos        = FirstIdx;
      frame_crc        = CrcInit;
      payload_shift    = '0;
      mismatch_count   = 0;
      readings_pending = 0;
    end else begin
      // Results are compared before this edge's byte is predicted, so a byte and
      // a result taken at the same edge never pair up with each other.
      if (readings_mon.valid && readings_mon.ready) begin
        got_rd.humidity    = readings_mon.humidity_milli_pct;
        got_rd.temperature = readings_mon.temperature_milli_c;
        got_rd.crc_error   = readings_mon.crc_error;
        if (expected_readings.size() == 0) begin
          report_mismatch("reading with no frame pending", '0, got_rd);
        end else begin
          exp_rd = expected_readings.pop_front();
          if (got_rd.humidity !== exp_rd.humidity ||
              got_rd.temperature !== exp_rd.temperature ||
              got_rd.crc_error !== exp_rd.crc_error) begin
            report_mismatch("reading mismatch", exp_rd, got_rd);
          end
        end
      end
      if (bytes_mon.valid && bytes_mon.ready) begin
        if (decode_byte(bytes_mon.rx_byte, bytes_mon.frame_start, new_rd)) begin
          expected_readings.push_back(new_rd);
        end
      end
      readings_pending = expected_readings.size();
    end
  end

endmodule

[tb/tb_humidity_temp_frame_decoder_top.sv]
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder_top;
  import htfd_pkg::*;
  import htfd_frame_math_pkg::*;

  // Ceiling on the run, in clock cycles. The slowest legal run has the sender
  // idling at a 78 percent chance and the receiver stalling on top of it.
  localparam int unsigned CycleLimit     = 300000;
  localparam int unsigned HoldoffCycles  = 150;
  localparam int unsigned RandomBytes    = 1600;
  localparam int unsigned DrainCycles    = 10;

  logic clk_i;
  logic rst_ni;

  htfd_in_if  byte_ch ();
  htfd_out_if reading_ch ();

  int mismatch_count;
  int readings_pending;

  // Idle chances in percent for each side, set per phase by the stimulus.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          holdoff_req;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  // True when the stimulus knows the block sits between two frames, so a
  // frame may begin without the frame-start flag.
  bit          at_boundary;

  humidity_temp_frame_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (reading_ch)
  );

  htfd_frame_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .bytes_mon        (byte_ch),
    .readings_mon     (reading_ch),
    .mismatch_count   (mismatch_count),
    .readings_pending (readings_pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: a hang or lost result ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side. Ready is decided once per falling edge. The one long hold-off
  // lets the frame register and the result register both fill up, so the
  // block must drop its input ready while the sender keeps offering bytes.
  initial begin
    int unsigned holdoff_left;
    holdoff_left     = 0;
    reading_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HoldoffCycles;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        reading_ch.ready <= 1'b0;
      end else begin
        reading_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request on the byte channel and waits until it is taken. Valid
  // stays high from one request to the next unless the sender idles, so it is
  // never lowered and raised within one time step.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic start);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.rx_byte     <= b;
    byte_ch.frame_start <= start;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Sends the first keep_bytes bytes of a frame: a random status byte, the
  // five payload bytes and the CRC byte, which is spoiled when bad_crc is set.
  // Cutting a frame short leaves the block in the middle of a frame.
  task automatic send_frame(input logic [PayloadW-1:0] payload, input logic lead_start,
                            input bit bad_crc, input int unsigned keep_bytes);
    logic [ByteW-1:0] crc;
    logic [ByteW-1:0] b;
    crc = CrcInit;
    for (int k = 0; k < keep_bytes && k < FrameBytes; k++) begin
      if (k == 0) begin
        b = ByteW'($urandom_range(255));
      end else if (k < FrameBytes - 1) begin
        b = payload[PayloadW-1-ByteW*(k-1) -: ByteW];
      end else begin
        b = bad_crc ? (crc ^ ByteW'($urandom_range(1, 255))) : crc;
      end
      if (k < FrameBytes - 1) begin
        crc = crc8_poly31(crc, b);
      end
      send_byte(b, (k == 0) ? lead_start : 1'b0);
    end
    at_boundary = (keep_bytes >= FrameBytes);
  endtask

  // Picks a 20-bit raw field, leaning toward the two ends of its range.
  function automatic logic [RawW-1:0] pick_raw();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      return '0;
    end else if (roll < 16) begin
      return '1;
    end
    return RawW'($urandom());
  endfunction

  // Stimulus: reset, a short directed part, then three phases of random
  // traffic with different idle patterns, then a drain and the verdict.
  initial begin
    int unsigned phase_end;
    int unsigned roll;
    byte_ch.valid       = 1'b0;
    byte_ch.rx_byte     = '0;
    byte_ch.frame_start = 1'b0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    holdoff_req         = 1'b0;
    bytes_sent          = 0;
    at_boundary         = 1'b1;
    rst_ni              = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. An all-zero payload with a good CRC gives the lowest
    // humidity and temperature. The next frame follows the first one without
    // the frame-start flag, carries an all-ones payload for the highest
    // readings and a spoiled CRC byte, which must still produce a reading.
    send_frame('0, 1'b1, 1'b0, FrameBytes);
    send_frame('1, 1'b0, 1'b1, FrameBytes);
    // A frame dropped after three bytes, restarted by the frame-start flag.
    send_frame(PayloadW'($urandom()), 1'b1, 1'b0, 3);
    send_frame({20'h80000, 20'h7FFFF}, 1'b1, 1'b0, FrameBytes);

    // Random part: mostly whole frames with random content, some with a bad
    // CRC, the rest cut-off frames and loose bytes with a random start flag.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          holdoff_req   = 1'b1;
        end
      endcase
      phase_end = bytes_sent + RandomBytes / 3;
      while (bytes_sent < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 78) begin
          send_frame({pick_raw(), pick_raw()},
                     at_boundary ? logic'($urandom_range(1)) : 1'b1,
                     ($urandom_range(99) < 20), FrameBytes);
        end else if (roll < 88) begin
          send_frame(PayloadW'({$urandom(), $urandom()}), logic'($urandom_range(1)),
                     1'b0, $urandom_range(1, FrameBytes - 1));
        end else begin
          send_byte(ByteW'($urandom_range(255)), ($urandom_range(3) == 0));
          at_boundary = 1'b0;
        end
      end
    end

    @(negedge clk_i);
    byte_ch.valid <= 1'b0;

    // Wait for every predicted reading, then keep the checker watching so a stray
    // extra result would still be caught.
    while (readings_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_if.sv
hw/rtl/htfd_frame.sv
hw/rtl/htfd_scale.sv
hw/rtl/humidity_temp_frame_decoder_top.sv
tb/htfd_frame_checker.sv
tb/tb_humidity_temp_frame_decoder_top.sv
